// ===== rtl/jnc_pkg.sv =====
`default_nettype none

package jnc_pkg;

  // pipeline depth of each section
  localparam int unsigned NsStages    = 4;
  localparam int unsigned DayStages   = 4;
  localparam int unsigned CivilStages = 5;

  // nanoseconds to seconds
  localparam logic [63:0] NsPerSec    = 64'd1_000_000_000;
  localparam logic [63:0] NsRecipFull = 64'hFFFF_FFFF_FFFF_FFFF / NsPerSec;
  localparam int unsigned RecipSplit  = 18;
  localparam logic [17:0] NsRecipLo   = NsRecipFull[17:0];
  localparam logic [16:0] NsRecipHi   = NsRecipFull[34:18];
  localparam logic [29:0] NsPerSec30  = NsPerSec[29:0];
  localparam logic [31:0] NsPerSec32  = NsPerSec[31:0];
  localparam logic [31:0] NsPerSec2x  = 32'(2 * NsPerSec);

  // the input is biased by 2^63 so the split works on an unsigned value
  localparam logic [63:0] SignOffset = 64'h8000_0000_0000_0000;
  localparam logic [29:0] OffsetRem  = 30'(SignOffset % NsPerSec);
  localparam logic [63:0] OffsetQuo  = SignOffset / NsPerSec;
  localparam logic [29:0] NsAddBack  = 30'(NsPerSec - 64'(OffsetRem));

  // seconds to days, counted from the 0000-03-01 era origin at midnight
  localparam logic [63:0] SecPerDay  = 64'd86_400;
  localparam logic [63:0] HalfDay    = 64'd43_200;
  localparam logic [63:0] EraShift   = 64'd719_468;
  localparam logic [63:0] J2000Days  = 64'd10_957;
  localparam logic [36:0] DayOrigin  =
    37'(SecPerDay * (J2000Days + EraShift) + HalfDay - OffsetQuo - 64'd1);
  localparam logic [63:0] DayOdd     = SecPerDay >> 7;
  localparam logic [30:0] DayRecip   = 31'((64'd1 << 40) / DayOdd);
  localparam logic [17:0] SecPerDay18 = SecPerDay[17:0];

  // era algorithm
  localparam logic [17:0] DaysPerEra  = 18'd146_097;
  localparam logic [15:0] DaysPerCent = 16'd36_524;
  localparam logic [17:0] LastDoe     = 18'd146_096;
  localparam logic [17:0] DaysPerYear = 18'd365;
  localparam logic [11:0] YearsPerEra = 12'd400;
  localparam logic [8:0]  YearsPerCent = 9'd100;
  localparam logic [18:0] Recip1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [3:0]  MarchBase = 4'd3;
  localparam logic [3:0]  JanShift  = 4'd9;
  localparam logic [3:0]  JanIndex  = 4'd10;

  // time of day
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;
  localparam logic [17:0] HourRecip  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MinRecip   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  typedef struct packed {
    logic [34:0] biased_sec;
    logic [29:0] biased_ns;
  } ns_split_t;

  typedef struct packed {
    logic [19:0] day_count;
    logic [16:0] sod;
    logic [29:0] sub_ns;
  } day_split_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  whole_second;
    logic [29:0] nanosecond;
  } civil_t;

  // first day of year of each month, year starting in march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/j2000_nanoseconds_to_civil.sv =====
// Converts a signed count of nanoseconds since J2000 noon into the proleptic
// Gregorian date and the time of day, with whole seconds and a separate floor
// nanosecond remainder. One item is accepted per clock while the output is
// taken as it appears. Of the stages, 4 split nanoseconds from seconds, 4
// split days from seconds of day, and 5 run the era calendar and the hour,
// minute and second split. Each stage of the first two sections holds at
// most one constant multiplication, and every stage can move on as soon as
// the one after it frees up, so a stall at the output fills the bubbles
// first and only then holds the input.
`default_nettype none

module j2000_nanoseconds_to_civil (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // epoch_ns
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // year, month, day, hour, minute, whole_second, nanosecond, zero fill
  output logic [71:0] m_axis_tdata
);
  import jnc_pkg::*;

  logic       ns_valid, ns_ready;
  ns_split_t  ns_data;
  logic       day_valid, day_ready;
  day_split_t day_data;
  civil_t     civil;

  jnc_ns_split u_ns_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .epoch_ns_i(s_axis_tdata),
    .valid_o   (ns_valid),
    .ready_i   (ns_ready),
    .data_o    (ns_data)
  );

  jnc_day_split u_day_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(ns_valid),
    .ready_o(ns_ready),
    .data_i (ns_data),
    .valid_o(day_valid),
    .ready_i(day_ready),
    .data_o (day_data)
  );

  jnc_civil u_civil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(day_valid),
    .ready_o(day_ready),
    .data_i (day_data),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (civil)
  );

  assign m_axis_tdata = {4'd0, civil.nanosecond, civil.whole_second, civil.minute,
                         civil.hour, civil.day, civil.month, civil.year};

endmodule

`default_nettype wire

// ===== rtl/jnc_pipe_ctrl.sv =====
`default_nettype none

module jnc_pipe_ctrl #(
  parameter int unsigned Depth = jnc_pkg::NsStages
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Depth-1:0] load_o
);
  import jnc_pkg::*;

  logic [Depth-1:0] vld_q, vld_d;
  logic [Depth:0]   rdy;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[Depth] = ready_i;
    for (int i = Depth - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? valid_i : vld_q[0];
    for (int i = 1; i < Depth; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[Depth-1];
  assign load_o  = rdy[Depth-1:0];

endmodule

`default_nettype wire

// ===== rtl/jnc_ns_split.sv =====
`default_nettype none

module jnc_ns_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [63:0]         epoch_ns_i,
  output logic                valid_o,
  input  logic                ready_i,
  output jnc_pkg::ns_split_t  data_o
);
  import jnc_pkg::*;

  logic [NsStages-1:0] load;

  logic [63:0] biased;
  logic [52:0] prod_lo;
  logic [63:0] biased_q;
  logic [52:0] prod_lo_q;

  logic [69:0] prod_full;
  logic [34:0] quo2_q;
  logic [31:0] low2_q;

  logic [31:0] qd_lo;
  logic [34:0] quo3_q;
  logic [31:0] rem3_q;

  logic [34:0] quo4_d, quo4_q;
  logic [31:0] rem4_full;
  logic [29:0] rem4_q;

  jnc_pipe_ctrl #(
    .Depth(NsStages)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .load_o (load)
  );

  // stage 1: bias to unsigned, low partial product of the reciprocal
  assign biased  = {~epoch_ns_i[63], epoch_ns_i[62:0]};
  assign prod_lo = 53'(biased[63:29]) * 53'(NsRecipLo);

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      biased_q  <= biased;
      prod_lo_q <= prod_lo;
    end
  end

  // stage 2: high partial product, quotient estimate low by at most two
  assign prod_full = (70'(biased_q[63:29]) * 70'(NsRecipHi) << RecipSplit)
                   + 70'(prod_lo_q);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      quo2_q <= prod_full[69:35];
      low2_q <= biased_q[31:0];
    end
  end

  // stage 3: remainder of the estimate, only the low 32 bits matter
  assign qd_lo = 32'(64'(quo2_q[31:0]) * 64'(NsPerSec30));

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      quo3_q <= quo2_q;
      rem3_q <= low2_q - qd_lo;
    end
  end

  // stage 4: correct the estimate
  always_comb begin
    if (rem3_q >= NsPerSec2x) begin
      quo4_d    = quo3_q + 35'd2;
      rem4_full = rem3_q - NsPerSec2x;
    end else if (rem3_q >= NsPerSec32) begin
      quo4_d    = quo3_q + 35'd1;
      rem4_full = rem3_q - NsPerSec32;
    end else begin
      quo4_d    = quo3_q;
      rem4_full = rem3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      quo4_q <= quo4_d;
      rem4_q <= rem4_full[29:0];
    end
  end

  assign data_o.biased_sec = quo4_q;
  assign data_o.biased_ns  = rem4_q;

endmodule

`default_nettype wire

// ===== rtl/jnc_day_split.sv =====
`default_nettype none

module jnc_day_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  jnc_pkg::ns_split_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output jnc_pkg::day_split_t data_o
);
  import jnc_pkg::*;

  logic [DayStages-1:0] load;

  logic        borrow;
  logic [29:0] sub_ns;
  logic [36:0] total;
  logic [36:0] total_q;
  logic [29:0] ns1_q;

  logic [60:0] prod_day;
  logic [19:0] qe2_q;
  logic [17:0] low2_q;
  logic [29:0] ns2_q;

  logic [17:0] qd_lo;
  logic [19:0] qe3_q;
  logic [17:0] rem3_q;
  logic [29:0] ns3_q;

  logic [19:0] day_d;
  logic [17:0] sod_d;
  logic [19:0] day_q;
  logic [16:0] sod_q;
  logic [29:0] ns4_q;

  jnc_pipe_ctrl #(
    .Depth(DayStages)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .load_o (load)
  );

  // stage 1: remove the bias, floor remainder, rebase seconds to era midnight
  assign borrow = data_i.biased_ns < OffsetRem;
  assign sub_ns = borrow ? data_i.biased_ns + NsAddBack : data_i.biased_ns - OffsetRem;
  assign total  = {2'd0, data_i.biased_sec} + DayOrigin + {36'd0, !borrow};

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      total_q <= total;
      ns1_q   <= sub_ns;
    end
  end

  // stage 2: day estimate, divide by 128 then by 675, low by at most one
  assign prod_day = 61'(total_q[36:7]) * 61'(DayRecip);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      qe2_q  <= prod_day[59:40];
      low2_q <= total_q[17:0];
      ns2_q  <= ns1_q;
    end
  end

  // stage 3: seconds left over, below two days
  assign qd_lo = 18'(36'(qe2_q[17:0]) * 36'(SecPerDay18));

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      qe3_q  <= qe2_q;
      rem3_q <= low2_q - qd_lo;
      ns3_q  <= ns2_q;
    end
  end

  // stage 4: correct
  always_comb begin
    if (rem3_q >= SecPerDay18) begin
      day_d = qe3_q + 20'd1;
      sod_d = rem3_q - SecPerDay18;
    end else begin
      day_d = qe3_q;
      sod_d = rem3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      day_q <= day_d;
      sod_q <= sod_d[16:0];
      ns4_q <= ns3_q;
    end
  end

  assign data_o.day_count = day_q;
  assign data_o.sod       = sod_q;
  assign data_o.sub_ns    = ns4_q;

endmodule

`default_nettype wire

// ===== rtl/jnc_civil.sv =====
`default_nettype none

module jnc_civil (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  jnc_pkg::day_split_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output jnc_pkg::civil_t     data_o
);
  import jnc_pkg::*;

  logic [CivilStages-1:0] load;

  // stage 1
  logic [2:0]  era;
  logic [20:0] era_base;
  logic [34:0] prod_hour;
  logic [17:0] doe1_q;
  logic [2:0]  era1_q;
  logic [4:0]  hour1_q;
  logic [16:0] sod1_q;
  logic [29:0] ns1_q;

  // stage 2
  logic [36:0] prod_1460;
  logic [2:0]  q_cent;
  logic [17:0] yoe_num;
  logic [11:0] hour_secs;
  logic [17:0] yoe_num2_q;
  logic [17:0] doe2_q;
  logic [2:0]  era2_q;
  logic [4:0]  hour2_q;
  logic [11:0] mrem2_q;
  logic [29:0] ns2_q;

  // stage 3
  logic [36:0] prod_365;
  logic [24:0] prod_min;
  logic [8:0]  yoe3_q;
  logic [17:0] doe3_q;
  logic [2:0]  era3_q;
  logic [4:0]  hour3_q;
  logic [5:0]  min3_q;
  logic [11:0] mrem3_q;
  logic [29:0] ns3_q;

  // stage 4
  logic [1:0]  q100;
  logic [17:0] year_days;
  logic [17:0] doy_full;
  logic [5:0]  min_secs;
  logic [8:0]  doy4_q;
  logic [8:0]  yoe4_q;
  logic [2:0]  era4_q;
  logic [4:0]  hour4_q;
  logic [5:0]  min4_q;
  logic [5:0]  sec4_q;
  logic [29:0] ns4_q;

  // stage 5
  logic [3:0]  mp;
  logic [8:0]  day_of_month;
  civil_t      out_d, out_q;

  jnc_pipe_ctrl #(
    .Depth(CivilStages)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .load_o (load)
  );

  // stage 1: era and day of era, hour of day
  always_comb begin
    era = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (data_i.day_count >= 20'(k * DaysPerEra)) era = 3'(k);
    end
  end

  assign era_base  = 21'(era) * 21'(DaysPerEra);
  assign prod_hour = 35'(data_i.sod) * 35'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      doe1_q  <= 18'(data_i.day_count - era_base[19:0]);
      era1_q  <= era;
      hour1_q <= prod_hour[33:29];
      sod1_q  <= data_i.sod;
      ns1_q   <= data_i.sub_ns;
    end
  end

  // stage 2: leap day corrections of the day of era, seconds within the hour
  assign prod_1460 = 37'(doe1_q) * 37'(Recip1460);

  always_comb begin
    q_cent = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if (doe1_q >= 18'(k * DaysPerCent)) q_cent = 3'(k);
    end
  end

  assign yoe_num   = doe1_q - 18'(prod_1460[35:29]) + 18'(q_cent)
                   - 18'(doe1_q == LastDoe);
  assign hour_secs = 12'(17'(hour1_q) * 17'(SecPerHour));

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      yoe_num2_q <= yoe_num;
      doe2_q     <= doe1_q;
      era2_q     <= era1_q;
      hour2_q    <= hour1_q;
      mrem2_q    <= sod1_q[11:0] - hour_secs;
      ns2_q      <= ns1_q;
    end
  end

  // stage 3: year of era, minute
  assign prod_365 = 37'(yoe_num2_q) * 37'(Recip365);
  assign prod_min = 25'(mrem2_q) * 25'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      yoe3_q  <= prod_365[35:27];
      doe3_q  <= doe2_q;
      era3_q  <= era2_q;
      hour3_q <= hour2_q;
      min3_q  <= prod_min[23:18];
      mrem3_q <= mrem2_q;
      ns3_q   <= ns2_q;
    end
  end

  // stage 4: day of year, second
  always_comb begin
    q100 = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (yoe3_q >= 9'(k * YearsPerCent)) q100 = 2'(k);
    end
  end

  assign year_days = 18'(yoe3_q) * DaysPerYear + 18'(yoe3_q >> 2) - 18'(q100);
  assign doy_full  = doe3_q - year_days;
  assign min_secs  = 6'(12'(min3_q) * 12'(SecPerMin));

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      doy4_q  <= doy_full[8:0];
      yoe4_q  <= yoe3_q;
      era4_q  <= era3_q;
      hour4_q <= hour3_q;
      min4_q  <= min3_q;
      sec4_q  <= mrem3_q[5:0] - min_secs;
      ns4_q   <= ns3_q;
    end
  end

  // stage 5: month from the march-based month table, then the year
  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy4_q >= month_start(4'(i))) mp = 4'(i);
    end
  end

  assign day_of_month = doy4_q - month_start(mp) + 9'd1;

  always_comb begin
    out_d.year         = 12'(yoe4_q) + 12'(era4_q) * YearsPerEra + 12'(mp >= JanIndex);
    out_d.month        = (mp < JanIndex) ? mp + MarchBase : mp - JanShift;
    out_d.day          = day_of_month[4:0];
    out_d.hour         = hour4_q;
    out_d.minute       = min4_q;
    out_d.whole_second = sec4_q;
    out_d.nanosecond   = ns4_q;
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/jnc_checker.sv =====
`default_nettype none

module jnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // a result that waits keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  else $error("stalled result changed");

  // input is held back only when the pipe is full behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
  else $error("input stalled with room in the pipe");

  // every reachable instant lies between 1707 and 2292
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[11:0] >= 12'd1707 && m_axis_tdata[11:0] <= 12'd2292)
  else $error("year out of range");

  // date and time fields within their calendar ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:12] >= 4'd1 && m_axis_tdata[15:12] <= 4'd12
                   && m_axis_tdata[20:16] >= 5'd1 && m_axis_tdata[20:16] <= 5'd31
                   && m_axis_tdata[25:21] <= 5'd23 && m_axis_tdata[31:26] <= 6'd59
                   && m_axis_tdata[37:32] <= 6'd59
                   && m_axis_tdata[67:38] <= 30'd999_999_999
                   && m_axis_tdata[71:68] == 4'd0)
  else $error("calendar field out of range");

endmodule

bind j2000_nanoseconds_to_civil jnc_checker u_jnc_checker (.*);

`default_nettype wire

// ===== verif/j2000_nanoseconds_to_civil_test.sv =====
`timescale 1ns / 100ps

module j2000_nanoseconds_to_civil_test;

  localparam longint NsPerSec  = 64'sd1_000_000_000;
  localparam longint SecPerDay = 64'sd86_400;
  localparam longint HalfDay   = 64'sd43_200;
  localparam int     RandomItems = 850;
  localparam int     HoldCycles  = 300;

  typedef struct {
    logic [63:0]     epoch;
    jnc_pkg::civil_t civil;
  } civil_due_t;

  class civil_book;
    civil_due_t civil_due[$];
    int         converted;
    int         checked;
    int         failures;
    int         before_j2000;
    int         year_lo;
    int         year_hi;

    function new();
      converted    = 0;
      checked      = 0;
      failures     = 0;
      before_j2000 = 0;
      year_lo      = 4095;
      year_hi      = 0;
    endfunction

    // quotient rounded toward minus infinity, remainder in [0, d)
    function automatic longint floor_div(longint n, longint d, output longint r);
      longint q;
      q = n / d;
      r = n % d;
      if (r < 0) begin
        r += d;
        q -= 1;
      end
      return q;
    endfunction

    function automatic jnc_pkg::civil_t civil_of(logic [63:0] epoch);
      jnc_pkg::civil_t c;
      longint ns, sub_ns, secs, days, sod, era, doe, yoe, doy, mp, mm, dd, yy;
      ns   = $signed(epoch);
      secs = floor_div(ns, NsPerSec, sub_ns);
      days = floor_div(secs + HalfDay, SecPerDay, sod);
      // day 0 of the era count is 0000-03-01
      era  = floor_div(days + 64'sd10_957 + 64'sd719_468, 64'sd146_097, doe);
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      dd   = doy - (153 * mp + 2) / 5 + 1;
      mm   = (mp < 10) ? mp + 3 : mp - 9;
      yy   = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
      c.year         = 12'(yy);
      c.month        = 4'(mm);
      c.day          = 5'(dd);
      c.hour         = 5'(sod / 3600);
      c.minute       = 6'((sod % 3600) / 60);
      c.whole_second = 6'(sod % 60);
      c.nanosecond   = 30'(sub_ns);
      return c;
    endfunction

    function void note_epoch(logic [63:0] epoch);
      civil_due_t e;
      e.epoch = epoch;
      e.civil = civil_of(epoch);
      civil_due.push_back(e);
      converted++;
      if (epoch[63]) before_j2000++;
      if (e.civil.year < year_lo) year_lo = e.civil.year;
      if (e.civil.year > year_hi) year_hi = e.civil.year;
    endfunction

    function int pending();
      return civil_due.size();
    endfunction

    function void compare(string field, logic [63:0] epoch, int unsigned want,
                          int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: epoch_ns %0d %s expected %0d actual %0d", $time,
                 $signed(epoch), field, want, got);
      end
    endfunction

    // tdata from bit 0: year, month, day, hour, minute, whole_second, nanosecond
    function void check_civil(logic [71:0] d);
      civil_due_t e;
      if (civil_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected item, expected none actual %h", $time, d);
        return;
      end
      e = civil_due.pop_front();
      checked++;
      compare("year",         e.epoch, e.civil.year,         d[11:0]);
      compare("month",        e.epoch, e.civil.month,        d[15:12]);
      compare("day",          e.epoch, e.civil.day,          d[20:16]);
      compare("hour",         e.epoch, e.civil.hour,         d[25:21]);
      compare("minute",       e.epoch, e.civil.minute,       d[31:26]);
      compare("whole_second", e.epoch, e.civil.whole_second, d[37:32]);
      compare("nanosecond",   e.epoch, e.civil.nanosecond,   d[67:38]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  civil_book book;
  bit        hold_request;

  j2000_nanoseconds_to_civil uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // instant at a given day after 2000-01-01 and second of that day
  function automatic logic [63:0] instant(longint day_n, longint sod, longint sub_ns);
    return ((day_n * SecPerDay + sod - HalfDay) * NsPerSec) + sub_ns;
  endfunction

  function automatic logic [63:0] random_epoch();
    int          r;
    logic [63:0] v;
    longint      near;
    r = $urandom_range(0, 99);
    v = {$urandom(), $urandom()};
    if (r < 50) return v;
    if (r < 70) begin
      near = $signed(v) >>> 24;
      return near;
    end
    if (r < 90) begin
      near = $signed($urandom_range(0, 200_000)) - 100_000;
      return instant(near, ($urandom_range(0, 1) != 0) ? 86_399 : 0,
                     $urandom_range(0, 999_999_999));
    end
    if (v[0]) return 64'h8000_0000_0000_0000 + v[19:1];
    return 64'h7FFF_FFFF_FFFF_FFFF - v[19:1];
  endfunction

  task automatic send_epoch(logic [63:0] epoch, int gap);
    s_axis_tdata  <= epoch;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_epoch(epoch);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_civil();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // sender
  initial begin
    logic [63:0] directed[$];
    int          burst;
    book          = new();
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    directed = '{
      64'd0, 64'd1, -64'sd1, 64'd999_999_999, 64'd1_000_000_000,
      -64'sd999_999_999, -64'sd1_000_000_000, -64'sd1_000_000_001,
      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
      instant(0, 0, 0), instant(-1, 86_399, 999_999_999),
      instant(59, 43_200, 0), instant(60, 0, 0),              // leap day, era start
      instant(365, 86_399, 999_999_999), instant(366, 0, 0),
      instant(-36_466, 0, 0), instant(-36_465, 0, 0),         // 1900 has no leap day
      instant(36_583, 86_399, 999_999_999), instant(36_584, 0, 0),
      instant(-20, 3_599, 999_999_999), instant(20, 3_600, 0)
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_epoch(directed[i], gap_len());
    drain_civil();

    burst = 0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 100) begin
        // output held off while items keep coming
        hold_request = 1'b1;
        burst = 60;
      end
      if (i == 450) drain_civil();
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
      if (burst > 0) begin
        burst--;
        send_epoch(random_epoch(), 0);
      end else begin
        send_epoch(random_epoch(), gap_len());
      end
    end
    drain_civil();
    repeat (30) @(posedge clk_i);

    $display("converted %0d timestamps, %0d of them before J2000, years %0d to %0d",
             book.converted, book.before_j2000, book.year_lo, book.year_hi);
    $display("directed: 64-bit extremes, second and day edges, leap and century days");
    if (book.failures == 0 && book.pending() == 0) begin
      $display("j2000_nanoseconds_to_civil: match");
    end else begin
      $display("j2000_nanoseconds_to_civil: mismatch");
    end
    $finish;
  end

  // receiver
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        n = gap_len();
        m_axis_tready <= 1'b0;
        repeat ((n > 0) ? n : 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_civil(m_axis_tdata);
  end

  initial begin
    #20_000_000;
    $display("j2000_nanoseconds_to_civil: mismatch");
    $finish;
  end

endmodule
